// ===== design/idcq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the indexed circular deque.
// No dependencies; imported by every module of the block.
package idcq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int ELEM_WIDTH_DEF = 32;

    // stream payload layout
    localparam int POS_W    = 8;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;
    localparam int RD_W     = 32;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [3:0] {
        ACT_ADD_FRONT = 4'd0,
        ACT_ADD_BACK  = 4'd1,
        ACT_REM_FRONT = 4'd2,
        ACT_REM_BACK  = 4'd3,
        ACT_READ      = 4'd4,
        ACT_WRITE     = 4'd5,
        ACT_INSERT    = 4'd6,
        ACT_REM_AT    = 4'd7,
        ACT_CLEAR     = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // what the request needs after its evaluation cycle
    typedef enum logic [2:0] {
        PLAN_DONE,
        PLAN_READ,
        PLAN_INSERT,
        PLAN_REM_SHIFT,
        PLAN_REM_LAST
    } plan_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MOD,
        S_RD_ADDR,
        S_SHIFT,
        S_DRAIN,
        S_FINISH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic take_in;
        logic apply;
        logic rd_issue;
        logic shift_step;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        plan_t plan;
        logic  mod_busy;
        logic  shift_last;
    } stat_t;

endpackage

// ===== design/idcq_mod.sv =====
`timescale 1ns / 1ps
// Restoring remainder unit: one dividend bit per cycle.
// Depends on idcq_pkg.
module idcq_mod #(
    parameter int CW = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [idcq_pkg::POS_W-1:0]   dividend,
    input  logic [CW-1:0]                divisor,
    output logic                         busy,
    output logic [CW-1:0]                remainder
);
    import idcq_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0] dvd_reg;
    logic [CW-1:0]    rem_reg;
    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             ge;

    assign trial = {rem_reg, dvd_reg[POS_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(POS_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= ge ? diff[CW-1:0] : trial[CW-1:0];
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/idcq_dp.sv =====
`timescale 1ns / 1ps
// Datapath: element memory, head/count registers, shift pipeline, result register.
// Depends on idcq_pkg and idcq_mod.
module idcq_dp #(
    parameter int DEPTH      = idcq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = idcq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [idcq_pkg::IN_W-1:0]   s_tdata,
    input  idcq_pkg::cmd_t              cmd,
    output idcq_pkg::stat_t             stat,
    output logic [idcq_pkg::OUT_W-1:0]  m_tdata
);
    import idcq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    logic [3:0]            act_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [ELEM_WIDTH-1:0] elem_reg;
    status_t               st_reg, st_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  pend_reg;
    logic [AW-1:0]         pend_addr_reg;
    logic [ELEM_WIDTH-1:0] rd_data_reg;
    logic [OUT_W-1:0]      out_reg;

    logic                  n_zero, full, idx_ok, last_idx;
    logic [CW-1:0]         idx_k;
    logic [AW-1:0]         head_dec, head_inc;
    status_t               status_c;
    plan_t                 plan_c;
    logic [CW-1:0]         src_k, k_rd;
    logic [POS_W-1:0]      mag;
    logic                  mod_busy;
    logic [CW-1:0]         rem;
    logic                  we, rd_en;
    logic [AW-1:0]         wa, ra;
    logic [ELEM_WIDTH-1:0] wd;
    logic                  read_ok;
    logic [RD_W-1:0]       rd_out;

    // logical index to physical slot; head + k stays below twice DEPTH
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [SW-1:0] sum;
        sum = SW'(h) + SW'(k);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign n_zero   = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign idx_ok   = !pos_reg[POS_W-1] && (CMPW'(pos_reg[POS_W-2:0]) < CMPW'(count_reg));
    assign idx_k    = CW'(pos_reg[POS_W-2:0]);
    assign last_idx = (SW'(idx_k) + SW'(1) == SW'(count_reg));
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        status_c = ST_OK;
        plan_c   = PLAN_DONE;
        unique case (act_reg)
            ACT_ADD_FRONT, ACT_ADD_BACK:
            begin
                if (full) status_c = ST_FULL;
            end
            ACT_REM_FRONT, ACT_REM_BACK, ACT_CLEAR:
            begin
                if (n_zero) status_c = ST_EMPTY;
            end
            ACT_READ:
            begin
                if (n_zero) status_c = ST_EMPTY;
                else        plan_c   = PLAN_READ;
            end
            ACT_WRITE:
            begin
                if (!idx_ok) status_c = ST_RANGE;
            end
            ACT_INSERT:
            begin
                if (!idx_ok)   status_c = ST_RANGE;
                else if (full) status_c = ST_FULL;
                else           plan_c   = PLAN_INSERT;
            end
            ACT_REM_AT:
            begin
                if (n_zero)        status_c = ST_EMPTY;
                else if (!idx_ok)  status_c = ST_RANGE;
                else if (last_idx) plan_c   = PLAN_REM_LAST;
                else               plan_c   = PLAN_REM_SHIFT;
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    // insert moves entries up (source below), remove moves them down
    assign src_k = (act_reg == ACT_INSERT) ? k_reg - 1'b1 : k_reg + 1'b1;

    assign mag  = pos_reg[POS_W-1] ? (~pos_reg + 1'b1) : pos_reg;
    assign k_rd = (pos_reg[POS_W-1] && rem != '0) ? count_reg - rem : rem;

    idcq_mod #(
        .CW (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.apply && plan_c == PLAN_READ),
        .dividend  (mag),
        .divisor   (count_reg),
        .busy      (mod_busy),
        .remainder (rem)
    );

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        st_next    = st_reg;
        k_next     = k_reg;
        we         = 1'b0;
        wa         = '0;
        wd         = elem_reg;
        if (cmd.apply)
        begin
            st_next = status_c;
            if (status_c == ST_OK)
            begin
                unique case (act_reg)
                    ACT_ADD_FRONT:
                    begin
                        head_next  = head_dec;
                        we         = 1'b1;
                        wa         = head_dec;
                        count_next = count_reg + 1'b1;
                    end
                    ACT_ADD_BACK:
                    begin
                        we         = 1'b1;
                        wa         = slot_of(head_reg, count_reg);
                        count_next = count_reg + 1'b1;
                    end
                    ACT_REM_FRONT:
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                    ACT_REM_BACK:
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    ACT_WRITE:
                    begin
                        we = 1'b1;
                        wa = slot_of(head_reg, idx_k);
                    end
                    ACT_INSERT:
                    begin
                        k_next = count_reg;
                    end
                    ACT_REM_AT:
                    begin
                        k_next = idx_k;
                    end
                    ACT_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        k_next = k_reg;
                    end
                endcase
            end
        end
        if (cmd.shift_step)
        begin
            k_next = src_k;
        end
        if (cmd.finish)
        begin
            if (act_reg == ACT_INSERT)
            begin
                we         = 1'b1;
                wa         = slot_of(head_reg, idx_k);
                count_next = count_reg + 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
        // write half of the shift pipeline, in the cycle after its read
        if (pend_reg)
        begin
            we = 1'b1;
            wa = pend_addr_reg;
            wd = rd_data_reg;
        end
    end

    assign rd_en = cmd.rd_issue || cmd.shift_step;
    assign ra    = cmd.rd_issue ? slot_of(head_reg, k_rd) : slot_of(head_reg, src_k);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= cmd.shift_step;
        end
    end

    assign read_ok = (st_reg == ST_OK) && (act_reg == ACT_READ);
    assign rd_out  = read_ok ? RD_W'(rd_data_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            act_reg  <= s_tdata[3:0];
            pos_reg  <= s_tdata[11:4];
            elem_reg <= ELEM_WIDTH'(s_tdata[43:12]);
        end
        st_reg        <= st_next;
        k_reg         <= k_next;
        pend_addr_reg <= slot_of(head_reg, k_reg);
        if (cmd.load_out)
        begin
            out_reg <= {6'b0, (count_reg == '0), CNT_OUT_W'(count_reg), st_reg, rd_out};
        end
    end

    assign stat.plan       = plan_c;
    assign stat.mod_busy   = mod_busy;
    assign stat.shift_last = (act_reg == ACT_INSERT)
                           ? (SW'(k_reg) == SW'(idx_k) + SW'(1))
                           : (SW'(k_reg) + SW'(2) == SW'(count_reg));
    assign m_tdata         = out_reg;

endmodule

// ===== design/idcq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences one request at a time and owns the output valid.
// Depends on idcq_pkg.
module idcq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  idcq_pkg::stat_t stat,
    output idcq_pkg::cmd_t  cmd
);
    import idcq_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid) state_next = S_EVAL;
            end
            S_EVAL:
            begin
                unique case (stat.plan)
                    PLAN_READ:      state_next = S_MOD;
                    PLAN_INSERT:    state_next = S_SHIFT;
                    PLAN_REM_SHIFT: state_next = S_SHIFT;
                    PLAN_REM_LAST:  state_next = S_FINISH;
                    default:        state_next = S_DONE;
                endcase
            end
            S_MOD:
            begin
                if (!stat.mod_busy) state_next = S_RD_ADDR;
            end
            S_RD_ADDR: state_next = S_DONE;
            S_SHIFT:
            begin
                if (stat.shift_last) state_next = S_DRAIN;
            end
            S_DRAIN:   state_next = S_FINISH;
            S_FINISH:  state_next = S_DONE;
            S_DONE:
            begin
                if (slot_free) state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.take_in    = (state_reg == S_IDLE) && s_tvalid;
        cmd.apply      = (state_reg == S_EVAL);
        cmd.rd_issue   = (state_reg == S_RD_ADDR);
        cmd.shift_step = (state_reg == S_SHIFT);
        cmd.finish     = (state_reg == S_FINISH);
        cmd.load_out   = (state_reg == S_DONE) && slot_free;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ===== design/indexed_circular_deque_top.sv =====
`timescale 1ns / 1ps
// Indexed circular deque, one request at a time. After accept each request is evaluated;
// add/remove/write/clear/errors then load the result, a read first runs the remainder unit and
// one memory read, and insert/remove-at first shift entries through the memory (up to DEPTH - 1
// moves, one per cycle) before the result is loaded.
// A new request can be taken in the cycle after the previous result is loaded, even while it waits.
// Reset (async, active low) empties the deque; memory contents are not cleared.
module indexed_circular_deque_top #(
    parameter int DEPTH      = idcq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = idcq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [3:0] action, [11:4] position, [43:12] element, [47:44] zero
    input  logic [idcq_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [31:0] read_value, [33:32] status, [40:34] count, [41] is_empty, [47:42] zero
    output logic [idcq_pkg::OUT_W-1:0]  m_tdata
);
    import idcq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    idcq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    idcq_dp #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

    // one request in flight: ready drops right after an accept
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take_in, cmd.apply, cmd.rd_issue, cmd.shift_step, cmd.finish,
                  cmd.load_out}))
        else $error("conflicting datapath commands");

endmodule

// ===== bench/indexed_circular_deque_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for indexed_circular_deque_top: directed corner requests, then random
// request streams checked against a behavioral deque that tracks every accepted request.
// Depends on idcq_pkg and the block's RTL only.
module indexed_circular_deque_top_test;
    import idcq_pkg::*;

    localparam int DQ_DEPTH    = 64;
    localparam int RAND_ITEMS  = 1800;
    localparam int IDLE_LIMIT  = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_EVERY  = 600;

    // packed so that action lands in the low bits, as on s_tdata
    typedef struct packed {
        logic [31:0] element;
        logic [7:0]  position;
        logic [3:0]  action;
    } request_t;

    // low 42 bits of m_tdata
    typedef struct packed {
        logic        is_empty;
        logic [6:0]  count;
        status_t     status;
        logic [31:0] read_value;
    } result_t;

    typedef enum int { MIX_GROW, MIX_SHRINK, MIX_EVEN } mix_t;

    localparam action_t ACT_ORDER [8] = '{ACT_ADD_BACK, ACT_ADD_FRONT, ACT_INSERT, ACT_READ,
                                          ACT_WRITE, ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT};
    localparam int CUT_GROW   [8] = '{30, 50, 65, 75, 83, 88, 93, 100};
    localparam int CUT_SHRINK [8] = '{10, 15, 20, 35, 45, 60, 75, 100};
    localparam int CUT_EVEN   [8] = '{18, 30, 42, 58, 70, 80, 90, 100};

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    request_t pending_requests [$];
    result_t  expected_results [$];

    // behavioral copy of the deque
    logic [31:0] shadow_mem [DQ_DEPTH];
    logic [5:0]  shadow_head  = '0;
    int          shadow_count = 0;

    int failures       = 0;
    int requests_taken = 0;
    int results_seen   = 0;
    int hold_left      = 0;
    int holds_done     = 0;
    int stall_cycles   = 0;
    int status_hits [4] = '{0, 0, 0, 0};
    int peak_count     = 0;
    int ignored_codes  = 0;

    int send_gap  = 0;
    int send_run  = 0;
    bit send_quiet;
    int take_wait = 0;
    int recv_run  = 0;
    bit recv_quiet;

    indexed_circular_deque_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [5:0] slot_of_index(int k);
        return 6'(int'(shadow_head) + k);
    endfunction

    // applies one request to the shadow deque and returns the result it should produce
    function automatic result_t deque_apply(request_t req);
        result_t res;
        int      n;
        int      pos;
        int      idx;
        int      k;
        bit      idx_ok;
        res        = '0;
        res.status = ST_OK;
        n          = shadow_count;
        pos        = $signed(req.position);
        idx_ok     = (pos >= 0) && (pos < n);
        idx        = (pos >= 0) ? pos : 0;
        case (req.action)
            ACT_ADD_FRONT:
            begin
                if (n >= DQ_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_head = shadow_head - 6'd1;
                    shadow_mem[shadow_head] = req.element;
                    shadow_count = n + 1;
                end
            end
            ACT_ADD_BACK:
            begin
                if (n >= DQ_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_mem[slot_of_index(n)] = req.element;
                    shadow_count = n + 1;
                end
            end
            ACT_REM_FRONT:
            begin
                if (n == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    shadow_head = shadow_head + 6'd1;
                    shadow_count = n - 1;
                end
            end
            ACT_REM_BACK:
            begin
                if (n == 0)
                    res.status = ST_EMPTY;
                else
                    shadow_count = n - 1;
            end
            ACT_READ:
            begin
                if (n == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    // negative index counts back from the end, both directions wrap
                    if (pos >= 0)
                        k = pos % n;
                    else
                    begin
                        k = (-pos) % n;
                        k = (k == 0) ? 0 : n - k;
                    end
                    res.read_value = shadow_mem[slot_of_index(k)];
                end
            end
            ACT_WRITE:
            begin
                if (!idx_ok)
                    res.status = ST_RANGE;
                else
                    shadow_mem[slot_of_index(idx)] = req.element;
            end
            ACT_INSERT:
            begin
                if (!idx_ok)
                    res.status = ST_RANGE;
                else if (n >= DQ_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (k = n; k > idx; k--)
                        shadow_mem[slot_of_index(k)] = shadow_mem[slot_of_index(k - 1)];
                    shadow_mem[slot_of_index(idx)] = req.element;
                    shadow_count = n + 1;
                end
            end
            ACT_REM_AT:
            begin
                if (n == 0)
                    res.status = ST_EMPTY;
                else if (!idx_ok)
                    res.status = ST_RANGE;
                else
                begin
                    for (k = idx; k + 1 < n; k++)
                        shadow_mem[slot_of_index(k)] = shadow_mem[slot_of_index(k + 1)];
                    shadow_count = n - 1;
                end
            end
            ACT_CLEAR:
            begin
                if (n == 0)
                    res.status = ST_EMPTY;
                else
                    shadow_count = 0;
            end
            default:
                ignored_codes++;
        endcase
        res.count    = 7'(shadow_count);
        res.is_empty = (shadow_count == 0);
        status_hits[res.status]++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        return res;
    endfunction

    // per-request wait; each stretch has either zero waits or random waits, picked at random
    function automatic int draw_wait(inout int run_left, inout bit quiet);
        if (run_left == 0)
        begin
            run_left = $urandom_range(5, 40);
            quiet    = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [3:0] pick_action(mix_t mix);
        int r;
        int j;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 4'(9 + $urandom_range(0, 6));    // undefined codes
        if (r < 3)
            return ACT_CLEAR;
        r = $urandom_range(0, 99);
        for (j = 0; j < 7; j++)
        begin
            if (mix == MIX_GROW && r < CUT_GROW[j])
                return ACT_ORDER[j];
            if (mix == MIX_SHRINK && r < CUT_SHRINK[j])
                return ACT_ORDER[j];
            if (mix == MIX_EVEN && r < CUT_EVEN[j])
                return ACT_ORDER[j];
        end
        return ACT_ORDER[7];
    endfunction

    function automatic logic [7:0] pick_position(int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 8'($urandom_range(0, (n > 0) ? n - 1 : 0));
        if (r < 85)
            return 8'(0 - $urandom_range(1, 128));
        if (r < 90)
            return 8'(n + $urandom_range(0, 3));   // at or just past the end
        if (r < 95)
            return ($urandom_range(0, 1) == 1) ? 8'h7f : 8'h80;
        return 8'($urandom());
    endfunction

    task automatic queue_request(logic [3:0] action, logic [7:0] position, logic [31:0] element);
        request_t req;
        req.action   = action;
        req.position = position;
        req.element  = element;
        pending_requests.push_back(req);
    endtask

    task automatic note_failure(string what, result_t want, result_t got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%t %s: expected rd=%h st=%0d cnt=%0d empty=%0d, got rd=%h st=%0d cnt=%0d empty=%0d",
                     $realtime, what, want.read_value, want.status, want.count, want.is_empty,
                     got.read_value, got.status, got.count, got.is_empty);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(deque_apply(request_t'(s_tdata[43:0])));
                requests_taken <= requests_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    s_tdata  <= {4'b0, pending_requests.pop_front()};
                    s_tvalid <= 1'b1;
                    send_gap = draw_wait(send_run, send_quiet);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver ready
    always @(posedge clk or negedge rst_n)
    begin : result_check
        result_t got;
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[41:0]);
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                    note_failure("unexpected result", '0, got);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_value !== want.read_value || got.status !== want.status ||
                        got.count !== want.count || got.is_empty !== want.is_empty)
                        note_failure("result mismatch", want, got);
                end
                take_wait = draw_wait(recv_run, recv_quiet);
            end
            else if (take_wait > 0)
                take_wait--;
            m_tready <= (take_wait == 0) && (hold_left == 0);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && results_seen >= HOLD_EVERY * (holds_done + 1))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("%t no handshake for %0d cycles", $realtime, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : stimulus
        request_t req;
        mix_t     mix;
        int       mix_left;
        int       i;
        int       r;
        mix_left = 0;
        mix      = MIX_EVEN;

        // empty-list behavior
        queue_request(ACT_READ, 8'd0, 32'h0);
        queue_request(ACT_REM_FRONT, 8'd0, 32'h0);
        queue_request(ACT_REM_BACK, 8'd0, 32'h0);
        queue_request(ACT_REM_AT, 8'd0, 32'h0);
        queue_request(ACT_CLEAR, 8'd0, 32'h0);
        queue_request(ACT_WRITE, 8'd0, 32'h1);
        queue_request(ACT_INSERT, 8'd0, 32'h2);
        // three elements, then wrapped and negative reads
        queue_request(ACT_ADD_BACK, 8'd0, 32'hffff_ffff);
        queue_request(ACT_ADD_FRONT, 8'hff, 32'h0);
        queue_request(ACT_ADD_BACK, 8'd0, 32'ha5a5_5a5a);
        queue_request(ACT_READ, 8'h7f, 32'h0);
        queue_request(ACT_READ, 8'h80, 32'h0);
        queue_request(ACT_READ, 8'hff, 32'h0);
        queue_request(ACT_READ, 8'hfd, 32'h0);
        // index checks on write, insert and remove at
        queue_request(ACT_WRITE, 8'hff, 32'hffff_ffff);
        queue_request(ACT_WRITE, 8'h7f, 32'hffff_ffff);
        queue_request(ACT_WRITE, 8'd2, 32'h1234_5678);
        queue_request(ACT_INSERT, 8'd1, 32'hdead_beef);
        queue_request(ACT_INSERT, 8'd4, 32'h0);
        queue_request(ACT_REM_AT, 8'd0, 32'h0);
        queue_request(ACT_REM_AT, 8'h80, 32'h0);
        queue_request(ACT_REM_AT, 8'd2, 32'h0);
        queue_request(4'hf, 8'h80, 32'hffff_ffff);
        queue_request(ACT_REM_BACK, 8'd0, 32'h0);
        queue_request(ACT_CLEAR, 8'd0, 32'h0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // random phases biased toward growing, shrinking or neither, so full and empty recur
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            while (pending_requests.size() >= 2)
                @(negedge clk);
            if (mix_left == 0)
            begin
                mix      = mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 120);
            end
            mix_left--;
            req.action   = pick_action(mix);
            req.position = pick_position(shadow_count);
            r = $urandom_range(0, 9);
            req.element  = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : 32'($urandom());
            pending_requests.push_back(req);
        end

        while (pending_requests.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Ran %0d requests, %0d results; peak fill %0d of %0d, %0d undefined codes.",
                 requests_taken, results_seen, peak_count, DQ_DEPTH, ignored_codes);
        $display("Status mix: ok %0d, empty %0d, out of range %0d, full %0d; %0d output holds.",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_RANGE],
                 status_hits[ST_FULL], holds_done);
        if (failures == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
